@@ sv/arb_pkg.sv @@
// Shared types, constants and rounding helpers for the arcball rotation tracker.
// Used by arb_mac, arb_divsqrt and arcball_rotation_tracker_top.
package arb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 18;
    localparam int OPND_W     = 27;
    localparam int ACC_W      = 56;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int DS_NUM_W   = 54;
    localparam int DS_DIV_W   = 44;
    localparam int DS_Q_W     = 44;
    localparam int DS_SQ_ITER = DS_NUM_W / 2;
    localparam int DS_REM_W   = 31;
    localparam int DS_CNT_W   = 6;
    localparam int HALF_W     = 12;
    localparam int CFG_W      = 13;
    localparam int POS_W      = 14;
    localparam int DXY_W      = 15;
    localparam int MAG_W      = 31;
    localparam int A_W        = 20;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [0:0] CFG_WIDTH  = 1'd0;
    localparam logic [0:0] CFG_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(768);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(64'd1 << (OUT_W - 1)));
    localparam logic signed [OUT_W-1:0] ID_W   = OUT_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic valid;
        logic clr;
        logic neg;
    } t_mac_req;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_ds_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ds_stat;

    // round half away from zero, then drop the fraction bits
    function automatic logic signed [ACC_W-1:0] shr_round(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] r;
        m = v[ACC_W-1] ? (~v + 1'b1) : v;
        r = (m + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[ACC_W-1] ? $signed(~r + 1'b1) : $signed(r);
    endfunction

    // clamp to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        if (v < SAT_LO) c = SAT_LO;
        return c[OUT_W-1:0];
    endfunction

endpackage

@@ sv/arcball_rotation_tracker_top.sv @@
// Arcball tracker: end words, unused kinds and moves with no drag go straight to the output
// register; a begin and a move during a drag first run the bit-serial divider, square root
// and multiply-accumulate steps that map the point onto the sphere and, for a move, update the rotation.
// Only one word is in flight; a finished word waits in the output register.
// Synchronous active-low reset: identity rotation, no drag, client size 1024 x 768.
module arcball_rotation_tracker_top import arb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,  // x_pos[13:0], y_pos[27:14], zero fill
    input  logic [1:0]       s_axis_tuser,  // kind[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [79:0]      m_axis_tdata   // rot_x, rot_y, rot_z, rot_w, dragging, zero fill
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [4:0] P_DIVX  = 5'd0;
    localparam logic [4:0] P_DIVY  = 5'd1;
    localparam logic [4:0] P_MAG   = 5'd2;
    localparam logic [4:0] P_SQZ   = 5'd3;
    localparam logic [4:0] P_EX    = 5'd4;
    localparam logic [4:0] P_EY    = 5'd5;
    localparam logic [4:0] P_LEN   = 5'd6;
    localparam logic [4:0] P_SQL   = 5'd7;
    localparam logic [4:0] P_DIVEX = 5'd8;
    localparam logic [4:0] P_DIVEY = 5'd9;
    localparam logic [4:0] P_A0    = 5'd10;
    localparam logic [4:0] P_A1    = 5'd11;
    localparam logic [4:0] P_A2    = 5'd12;
    localparam logic [4:0] P_A3    = 5'd13;
    localparam logic [4:0] P_Q0    = 5'd14;
    localparam logic [4:0] P_Q1    = 5'd15;
    localparam logic [4:0] P_Q2    = 5'd16;
    localparam logic [4:0] P_Q3    = 5'd17;

    localparam logic [MAG_W-1:0]  ONE_M = MAG_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ONE_SQ = ACC_W'(64'd1 << (2 * FRAC_BITS));

    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [2:0]       r_state;
    logic [4:0]       r_op;
    logic [1:0]       r_term;
    logic [1:0]       r_kind;
    logic             r_drag;
    logic [HALF_W-1:0] r_hw;
    logic [HALF_W-1:0] r_hh;
    logic signed [DXY_W-1:0]  r_dx;
    logic signed [DXY_W-1:0]  r_dy;
    logic [MAG_W-1:0]         r_xm;
    logic [MAG_W-1:0]         r_ym;
    logic signed [OPND_W-1:0] r_ex;
    logic signed [OPND_W-1:0] r_ey;
    logic [OPND_W-1:0]        r_len;
    logic signed [OUT_W-1:0]  r_s   [3];
    logic signed [OUT_W-1:0]  r_p   [3];
    logic signed [A_W-1:0]    r_a   [4];
    logic signed [OUT_W-1:0]  r_lat [4];
    logic signed [OUT_W-1:0]  r_cur [4];
    logic             r_ovalid;
    logic [79:0]      r_odata;

    logic             in_acc;
    logic [HALF_W-1:0] hw_c;
    logic [HALF_W-1:0] hh_c;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic             op_is_ds;
    logic [1:0]       last_term;
    logic             can_load;

    t_mac_req                 mac_req;
    logic signed [OPND_W-1:0] mac_a;
    logic signed [OPND_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  mac_acc;
    t_ds_req                  ds_req;
    t_ds_stat                 ds_stat;
    logic [DS_NUM_W-1:0]      ds_num;
    logic [OPND_W-1:0]        ds_den;
    logic [DS_Q_W-1:0]        ds_res;

    logic [DXY_W-1:0]         dxm;
    logic [DXY_W-1:0]         dym;
    logic [OPND_W-1:0]        exm;
    logic [OPND_W-1:0]        eym;
    logic signed [OUT_W-1:0]  x_in;
    logic signed [OUT_W-1:0]  y_in;
    logic signed [OUT_W-1:0]  x_out;
    logic signed [OUT_W-1:0]  y_out;
    logic signed [OUT_W-1:0]  pt [3];
    logic                     pt_ready;
    logic signed [ACC_W-1:0]  rnd;

    arb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    arb_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_stat  (ds_stat),
        .o_res   (ds_res)
    );

    // decode the input word and the half sizes
    assign px            = s_axis_tdata[POS_W-1:0];
    assign py            = s_axis_tdata[2*POS_W-1:POS_W];
    assign hw_c          = (r_cfg_w[CFG_W-1:1] == '0) ? HALF_W'(1) : r_cfg_w[CFG_W-1:1];
    assign hh_c          = (r_cfg_h[CFG_W-1:1] == '0) ? HALF_W'(1) : r_cfg_h[CFG_W-1:1];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign can_load      = !r_ovalid || m_axis_tready;

    // magnitudes and signed sphere coordinates
    assign dxm   = r_dx[DXY_W-1] ? DXY_W'(-r_dx) : DXY_W'(r_dx);
    assign dym   = r_dy[DXY_W-1] ? DXY_W'(-r_dy) : DXY_W'(r_dy);
    assign exm   = r_ex[OPND_W-1] ? OPND_W'(-r_ex) : OPND_W'(r_ex);
    assign eym   = r_ey[OPND_W-1] ? OPND_W'(-r_ey) : OPND_W'(r_ey);
    assign x_in  = r_dx[DXY_W-1] ? -$signed({1'b0, r_xm[OUT_W-2:0]}) : $signed({1'b0, r_xm[OUT_W-2:0]});
    assign y_in  = r_dy[DXY_W-1] ? -$signed({1'b0, r_ym[OUT_W-2:0]}) : $signed({1'b0, r_ym[OUT_W-2:0]});
    assign x_out = r_ex[OPND_W-1] ? -$signed({1'b0, r_xm[OUT_W-2:0]})
                                  : $signed({1'b0, r_xm[OUT_W-2:0]});
    assign y_out = r_ey[OPND_W-1] ? -$signed({1'b0, ds_res[OUT_W-2:0]})
                                  : $signed({1'b0, ds_res[OUT_W-2:0]});
    assign rnd   = shr_round(mac_acc);

    // pick the divider or root operation
    always_comb begin
        op_is_ds = r_op inside {P_DIVX, P_DIVY, P_SQZ, P_SQL, P_DIVEX, P_DIVEY};
        ds_req.start   = (r_state == S_ISSUE) && op_is_ds;
        ds_req.is_sqrt = (r_op == P_SQZ) || (r_op == P_SQL);
        ds_num = '0;
        ds_den = OPND_W'(1);
        case (r_op)
            P_DIVX: begin
                ds_num = (DS_NUM_W'(dxm) << FRAC_BITS) + DS_NUM_W'(r_hw >> 1);
                ds_den = OPND_W'(r_hw);
            end
            P_DIVY: begin
                ds_num = (DS_NUM_W'(dym) << FRAC_BITS) + DS_NUM_W'(r_hh >> 1);
                ds_den = OPND_W'(r_hh);
            end
            P_SQZ:   ds_num = DS_NUM_W'(ONE_SQ - mac_acc);
            P_SQL:   ds_num = DS_NUM_W'(mac_acc);
            P_DIVEX: begin
                ds_num = (DS_NUM_W'(exm) << FRAC_BITS) + DS_NUM_W'(r_len >> 1);
                ds_den = r_len;
            end
            P_DIVEY: begin
                ds_num = (DS_NUM_W'(eym) << FRAC_BITS) + DS_NUM_W'(r_len >> 1);
                ds_den = r_len;
            end
            default: ;
        endcase
    end

    // pick the multiply terms
    always_comb begin
        mac_a     = '0;
        mac_b     = '0;
        mac_req.neg = 1'b0;
        last_term = 2'd0;
        case (r_op)
            P_MAG: begin
                last_term = 2'd1;
                mac_a = (r_term == 2'd0) ? OPND_W'(x_in) : OPND_W'(y_in);
                mac_b = mac_a;
            end
            P_EX: begin
                mac_a = OPND_W'(r_dx);
                mac_b = $signed(OPND_W'(r_hh));
            end
            P_EY: begin
                mac_a = OPND_W'(r_dy);
                mac_b = $signed(OPND_W'(r_hw));
            end
            P_LEN: begin
                last_term = 2'd1;
                mac_a = (r_term == 2'd0) ? r_ex : r_ey;
                mac_b = mac_a;
            end
            P_A0: begin
                last_term = 2'd1;
                mac_req.neg = (r_term != 2'd0);
                mac_a = (r_term == 2'd0) ? OPND_W'(r_s[1]) : OPND_W'(r_s[2]);
                mac_b = (r_term == 2'd0) ? OPND_W'(r_p[2]) : OPND_W'(r_p[1]);
            end
            P_A1: begin
                last_term = 2'd1;
                mac_req.neg = (r_term != 2'd0);
                mac_a = (r_term == 2'd0) ? OPND_W'(r_s[2]) : OPND_W'(r_s[0]);
                mac_b = (r_term == 2'd0) ? OPND_W'(r_p[0]) : OPND_W'(r_p[2]);
            end
            P_A2: begin
                last_term = 2'd1;
                mac_req.neg = (r_term != 2'd0);
                mac_a = (r_term == 2'd0) ? OPND_W'(r_s[0]) : OPND_W'(r_s[1]);
                mac_b = (r_term == 2'd0) ? OPND_W'(r_p[1]) : OPND_W'(r_p[0]);
            end
            P_A3: begin
                last_term = 2'd2;
                case (r_term)
                    2'd0:    begin mac_a = OPND_W'(r_s[0]); mac_b = OPND_W'(r_p[0]); end
                    2'd1:    begin mac_a = OPND_W'(r_s[1]); mac_b = OPND_W'(r_p[1]); end
                    default: begin mac_a = OPND_W'(r_s[2]); mac_b = OPND_W'(r_p[2]); end
                endcase
            end
            P_Q0, P_Q1, P_Q2, P_Q3: begin
                last_term = 2'd3;
                case (r_term)
                    2'd0:    mac_a = OPND_W'(r_a[3]);
                    2'd1:    mac_a = OPND_W'(r_a[0]);
                    2'd2:    mac_a = OPND_W'(r_a[1]);
                    default: mac_a = OPND_W'(r_a[2]);
                endcase
                case (r_op)
                    P_Q0: begin
                        case (r_term)
                            2'd0:    mac_b = OPND_W'(r_lat[0]);
                            2'd1:    mac_b = OPND_W'(r_lat[3]);
                            2'd2:    mac_b = OPND_W'(r_lat[2]);
                            default: begin mac_b = OPND_W'(r_lat[1]); mac_req.neg = 1'b1; end
                        endcase
                    end
                    P_Q1: begin
                        case (r_term)
                            2'd0:    mac_b = OPND_W'(r_lat[1]);
                            2'd1:    begin mac_b = OPND_W'(r_lat[2]); mac_req.neg = 1'b1; end
                            2'd2:    mac_b = OPND_W'(r_lat[3]);
                            default: mac_b = OPND_W'(r_lat[0]);
                        endcase
                    end
                    P_Q2: begin
                        case (r_term)
                            2'd0:    mac_b = OPND_W'(r_lat[2]);
                            2'd1:    mac_b = OPND_W'(r_lat[1]);
                            2'd2:    begin mac_b = OPND_W'(r_lat[0]); mac_req.neg = 1'b1; end
                            default: mac_b = OPND_W'(r_lat[3]);
                        endcase
                    end
                    default: begin
                        mac_req.neg = (r_term != 2'd0);
                        case (r_term)
                            2'd0:    mac_b = OPND_W'(r_lat[3]);
                            2'd1:    mac_b = OPND_W'(r_lat[0]);
                            2'd2:    mac_b = OPND_W'(r_lat[1]);
                            default: mac_b = OPND_W'(r_lat[2]);
                        endcase
                    end
                endcase
            end
            default: ;
        endcase
        mac_req.valid = (r_state == S_ISSUE) && !op_is_ds;
        mac_req.clr   = (r_term == 2'd0);
    end

    // sphere point when it is complete
    always_comb begin
        pt_ready = (r_state == S_DONE) && ((r_op == P_SQZ) || (r_op == P_DIVEY));
        if (r_op == P_SQZ) begin
            pt[0] = x_in;
            pt[1] = y_in;
            pt[2] = $signed(ds_res[OUT_W-1:0]);
        end else begin
            pt[0] = x_out;
            pt[1] = y_out;
            pt[2] = '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RST;
            r_cfg_h <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= P_DIVX;
            r_term   <= 2'd0;
            r_drag   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_lat[i] <= (i == 3) ? ID_W : '0;
                r_cur[i] <= (i == 3) ? ID_W : '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= '0;
            end
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind <= s_axis_tuser;
                        r_hw   <= hw_c;
                        r_hh   <= hh_c;
                        r_dx   <= $signed({3'b000, hw_c}) - DXY_W'(px);
                        r_dy   <= DXY_W'(py) - $signed({3'b000, hh_c});
                        r_op   <= P_DIVX;
                        r_term <= 2'd0;
                        if (s_axis_tuser == KIND_END) begin
                            r_drag  <= 1'b0;
                            r_state <= S_FIN;
                        end else if (s_axis_tuser == KIND_BEGIN
                                     || (s_axis_tuser == KIND_MOVE && r_drag)) begin
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_ISSUE: begin
                    if (op_is_ds || r_term == last_term) begin
                        r_term  <= 2'd0;
                        r_state <= S_WAIT;
                    end else begin
                        r_term <= r_term + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (!op_is_ds || ds_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_ISSUE;
                    r_op    <= r_op + 1'b1;
                    case (r_op)
                        P_DIVX: r_xm <= ds_res[MAG_W-1:0];
                        P_DIVY: begin
                            r_ym <= ds_res[MAG_W-1:0];
                            if (r_xm > ONE_M || ds_res[MAG_W-1:0] > ONE_M) r_op <= P_EX;
                        end
                        P_MAG:  if (mac_acc > ONE_SQ) r_op <= P_EX;
                        P_EX:   r_ex <= mac_acc[OPND_W-1:0];
                        P_EY:   r_ey <= mac_acc[OPND_W-1:0];
                        P_SQL:  r_len <= (ds_res == '0) ? OPND_W'(1) : ds_res[OPND_W-1:0];
                        P_DIVEX: r_xm <= ds_res[MAG_W-1:0];
                        P_A0:   r_a[0] <= rnd[A_W-1:0];
                        P_A1:   r_a[1] <= rnd[A_W-1:0];
                        P_A2:   r_a[2] <= rnd[A_W-1:0];
                        P_A3:   r_a[3] <= rnd[A_W-1:0];
                        P_Q0:   r_cur[0] <= sat_out(rnd);
                        P_Q1:   r_cur[1] <= sat_out(rnd);
                        P_Q2:   r_cur[2] <= sat_out(rnd);
                        P_Q3: begin
                            r_cur[3] <= sat_out(rnd);
                            r_state  <= S_FIN;
                        end
                        default: ;
                    endcase
                    // latch the start point or go on to the rotation
                    if (pt_ready) begin
                        for (int i = 0; i < 3; i++) begin
                            r_p[i] <= pt[i];
                        end
                        if (r_kind == KIND_BEGIN) begin
                            for (int i = 0; i < 3; i++) begin
                                r_s[i] <= pt[i];
                            end
                            for (int i = 0; i < 4; i++) begin
                                r_lat[i] <= r_cur[i];
                            end
                            r_drag  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_op <= P_A0;
                        end
                    end
                end
                S_FIN: begin
                    if (can_load) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_drag, r_cur[3], r_cur[2], r_cur[1], r_cur[0]};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_drag_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_drag)) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_END))
        else $error("drag cleared without an end word");

    a_ds_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_req.start |-> !ds_stat.busy)
        else $error("divider started while busy");

    a_half_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_hw != '0 && r_hh != '0))
        else $error("zero half size in use");

    a_mac_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && !op_is_ds) |=> (r_state == S_DONE))
        else $error("accumulator wait overran");

endmodule

@@ sv/arb_mac.sv @@
// Shared signed multiply-accumulate unit of the arcball tracker.
// Depends on arb_pkg for widths and the request struct.
module arb_mac import arb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_req                 i_req,
    input  logic signed [OPND_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v;
    logic                     r_clr;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  base;

    // register the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_req.valid;
        end
        r_prod <= i_a * i_b;
        r_clr  <= i_req.clr;
        r_neg  <= i_req.neg;
    end

    assign base = r_clr ? '0 : r_acc;

    // add or subtract into the accumulator
    always_ff @(posedge i_clk) begin
        if (r_v) begin
            r_acc <= r_neg ? base - ACC_W'(r_prod) : base + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

@@ sv/arb_divsqrt.sv @@
// Bit-serial divider and rounding square root, one digit per cycle.
// Depends on arb_pkg for widths and the request and status structs.
module arb_divsqrt import arb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ds_req             i_req,
    input  logic [DS_NUM_W-1:0] i_num,
    input  logic [OPND_W-1:0]   i_den,
    output t_ds_stat            o_stat,
    output logic [DS_Q_W-1:0]   o_res
);

    logic [DS_NUM_W-1:0] r_num;
    logic [OPND_W-1:0]   r_den;
    logic [DS_REM_W-1:0] r_rem;
    logic [DS_Q_W-1:0]   r_q;
    logic [DS_CNT_W-1:0] r_cnt;
    logic                r_sqrt;
    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    logic [DS_Q_W-1:0]   r_res;

    logic [OPND_W:0]     div_sh;
    logic                div_ge;
    logic [DS_REM_W-1:0] sq_sh;
    logic [DS_REM_W-1:0] sq_trial;
    logic                sq_ge;
    logic [DS_REM_W-1:0] n_rem;
    logic [DS_NUM_W-1:0] n_num;
    logic                n_bit;

    // one digit of the quotient or the root
    always_comb begin
        div_sh   = {r_rem[OPND_W-1:0], r_num[DS_DIV_W-1]};
        div_ge   = div_sh >= {1'b0, r_den};
        sq_sh    = {r_rem[DS_REM_W-3:0], r_num[DS_NUM_W-1 -: 2]};
        sq_trial = DS_REM_W'({r_q[DS_SQ_ITER-1:0], 2'b01});
        sq_ge    = sq_sh >= sq_trial;
        if (r_sqrt) begin
            n_bit = sq_ge;
            n_rem = sq_ge ? sq_sh - sq_trial : sq_sh;
            n_num = r_num << 2;
        end else begin
            n_bit = div_ge;
            n_rem = DS_REM_W'(div_ge ? div_sh - {1'b0, r_den} : div_sh);
            n_num = r_num << 1;
        end
    end

    // sequence the digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_sqrt <= i_req.is_sqrt;
                r_cnt  <= i_req.is_sqrt ? DS_CNT_W'(DS_SQ_ITER) : DS_CNT_W'(DS_DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_q   <= {r_q[DS_Q_W-2:0], n_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DS_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                // round the root to nearest
                r_res  <= (r_sqrt && (DS_Q_W'(r_rem) > r_q)) ? r_q + 1'b1 : r_q;
            end
        end
    end

    assign o_stat.busy = r_busy | r_fin;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the arcball rotation tracker: pointer words in, rotation words out.
// Depends on arb_pkg and arcball_rotation_tracker_top; carries its own rotation predictor.
`timescale 1ns / 1ps
module tb_top;
    import arb_pkg::*;

    localparam int LIMIT = 2000000;
    localparam longint ONE = 64'sd1 << 16;

    typedef struct {
        logic [1:0] kind;
        int x;
        int y;
    } t_evt;

    // directed row: event plus a typed identity result where it is obvious
    typedef struct {
        logic [1:0] kind;
        int x;
        int y;
        bit fixed;
        bit drag;
    } t_row;

    typedef struct {
        logic signed [17:0] rx, ry, rz, rw;
        logic drag;
    } t_rot;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic [79:0] m_axis_tdata;

    arcball_rotation_tracker_top dut (.*);

    // predictor state
    longint cw, ch;
    bit pr_drag;
    longint latch_q[4], cur_q[4], start_p[3];
    t_rot expected_rot[$];
    int errors;
    longint cycles;
    bit long_hold;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint div_rnd(longint n, longint d);
        longint q;
        if (d <= 0) d = 1;
        q = (mag(n) + d / 2) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic longint rnd_shift(longint v);
        longint r;
        r = (mag(v) + (64'sd1 << 15)) >>> 16;
        return v < 0 ? -r : r;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic longint sqrt_rnd(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        for (b = 64'd1 << 31; b != 0; b >>= 1)
            if ((r + b) * (r + b) <= v) r = r + b;
        if (v - r * r > r) r++;
        return longint'(r);
    endfunction

    // map a pixel position onto the unit sphere
    task automatic map_sphere(input longint px, input longint py, output longint p[3]);
        longint hw, hh, dx, dy, x, y, ex, ey, len;
        bit outside;
        hw = cw / 2;
        hh = ch / 2;
        if (hw == 0) hw = 1;
        if (hh == 0) hh = 1;
        dx = hw - px;
        dy = py - hh;
        x = div_rnd(dx * ONE, hw);
        y = div_rnd(dy * ONE, hh);
        outside = mag(x) > ONE || mag(y) > ONE;
        if (!outside) begin
            if (x * x + y * y > ONE * ONE) outside = 1;
            else begin
                p[0] = x;
                p[1] = y;
                p[2] = sqrt_rnd(ONE * ONE - x * x - y * y);
            end
        end
        if (outside) begin
            ex = dx * hh;
            ey = dy * hw;
            len = sqrt_rnd(ex * ex + ey * ey);
            if (len == 0) len = 1;
            p[0] = div_rnd(ex * ONE, len);
            p[1] = div_rnd(ey * ONE, len);
            p[2] = 0;
        end
    endtask

    task automatic predict_rotation(input t_evt e);
        longint c[3], a[4], b[4], s[3];
        t_rot r;
        if (e.kind == KIND_BEGIN) begin
            pr_drag = 1;
            latch_q = cur_q;
            map_sphere(e.x, e.y, start_p);
        end else if (e.kind == KIND_MOVE && pr_drag) begin
            s = start_p;
            b = latch_q;
            map_sphere(e.x, e.y, c);
            a[0] = rnd_shift(s[1] * c[2] - s[2] * c[1]);
            a[1] = rnd_shift(s[2] * c[0] - s[0] * c[2]);
            a[2] = rnd_shift(s[0] * c[1] - s[1] * c[0]);
            a[3] = rnd_shift(s[0] * c[0] + s[1] * c[1] + s[2] * c[2]);
            cur_q[0] = clamp18(rnd_shift(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1]));
            cur_q[1] = clamp18(rnd_shift(a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0]));
            cur_q[2] = clamp18(rnd_shift(a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3]));
            cur_q[3] = clamp18(rnd_shift(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]));
        end else if (e.kind == KIND_END) begin
            pr_drag = 0;
        end
        r.rx = 18'(cur_q[0]);
        r.ry = 18'(cur_q[1]);
        r.rz = 18'(cur_q[2]);
        r.rw = 18'(cur_q[3]);
        r.drag = pr_drag;
        expected_rot.push_back(r);
    endtask

    // receiver: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 0;
        else if (long_hold) m_axis_tready <= 0;
        else m_axis_tready <= (cycles % 64) < 40 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    initial begin
        long_hold = 0;
        wait (cycles == 3000);
        long_hold = 1;
        repeat (2000) @(posedge i_clk);
        long_hold = 0;
    end

    // check each accepted result word
    always @(posedge i_clk) begin
        t_rot e;
        logic signed [17:0] ax, ay, az, aw;
        logic ad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            ax = m_axis_tdata[17:0];
            ay = m_axis_tdata[35:18];
            az = m_axis_tdata[53:36];
            aw = m_axis_tdata[71:54];
            ad = m_axis_tdata[72];
            if (expected_rot.size() == 0) begin
                $display("%0t: unexpected word %h", $realtime, m_axis_tdata);
                errors++;
            end else begin
                e = expected_rot.pop_front();
                if (ax !== e.rx || ay !== e.ry || az !== e.rz || aw !== e.rw || ad !== e.drag)
                begin
                    $display("%0t: expected %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                        $realtime, e.rx, e.ry, e.rz, e.rw, e.drag, ax, ay, az, aw, ad);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input t_evt e);
        s_axis_tvalid <= 1;
        s_axis_tuser <= e.kind;
        s_axis_tdata <= {4'b0, 14'(e.y), 14'(e.x)};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_rotation(e);
    endtask

    task automatic idle_gap();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (expected_rot.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_WIDTH) cw = v; else ch = v;
    endtask

    function automatic int rand_pos(int lo, int hi);
        return $urandom_range(0, 7) == 0 ? int'($urandom_range(0, 12287)) - 4096
                                          : int'($urandom_range(lo, hi));
    endfunction

    t_row dir_tbl[] = '{
        '{KIND_MOVE, 0, 0, 1, 0}, '{KIND_END, 0, 0, 1, 0}, '{2'd3, 100, 100, 1, 0},
        '{KIND_BEGIN, 512, 384, 1, 1}, '{KIND_MOVE, 512, 384, 1, 1},
        '{KIND_MOVE, 600, 300, 0, 0},
        '{KIND_MOVE, -4096, -4096, 0, 0}, '{KIND_MOVE, 8191, 8191, 0, 0},
        '{KIND_MOVE, 0, 384, 0, 0},
        '{KIND_MOVE, 1024, 768, 0, 0}, '{2'd3, 1, 1, 0, 0}, '{KIND_END, 5, 5, 0, 0},
        '{KIND_MOVE, 700, 700, 0, 0}, '{KIND_BEGIN, 8191, -4096, 0, 0},
        '{KIND_MOVE, -4096, 8191, 0, 0},
        '{KIND_BEGIN, 300, 200, 0, 0}, '{KIND_MOVE, 700, 500, 0, 0},
        '{KIND_END, 0, 0, 0, 0}
    };

    initial begin
        int sizes[6] = '{2, 4096, 3, 640, 8191, 0};
        int n;
        t_evt e;
        t_rot fx;
        errors = 0;
        cycles = 0;
        cw = 1024;
        ch = 768;
        pr_drag = 0;
        cur_q = '{0, 0, 0, ONE};
        latch_q = cur_q;
        start_p = '{0, 0, 0};
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed rows; identity rows right after reset carry a typed result
        foreach (dir_tbl[i]) begin
            e.kind = dir_tbl[i].kind;
            e.x = dir_tbl[i].x;
            e.y = dir_tbl[i].y;
            send_word(e);
            if (dir_tbl[i].fixed) begin
                fx.rx = '0;
                fx.ry = '0;
                fx.rz = '0;
                fx.rw = 18'(ONE);
                fx.drag = dir_tbl[i].drag;
                expected_rot[$] = fx;
            end
            if ($urandom_range(0, 1)) idle_gap();
        end
        drain();

        // random phases over several client sizes
        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_WIDTH, ph == 6 ? int'($urandom_range(0, 8191)) : sizes[ph - 1]);
                write_reg(CFG_HEIGHT, sizes[(ph + 2) % 6]);
            end
            n = 0;
            while (n < 70) begin
                // drag: a begin (sometimes another kind), several moves, usually an end
                e.kind = KIND_BEGIN;
                e.x = rand_pos(0, int'(cw));
                e.y = rand_pos(0, int'(ch));
                if ($urandom_range(0, 9) == 0) e.kind = 2'($urandom_range(1, 3));
                send_word(e);
                n++;
                repeat ($urandom_range(1, 8)) begin
                    e.kind = KIND_MOVE;
                    e.x = rand_pos(0, int'(cw));
                    e.y = rand_pos(0, int'(ch));
                    send_word(e);
                    n++;
                    if ($urandom_range(0, 3) == 0) idle_gap();
                end
                if ($urandom_range(0, 4) != 0) begin
                    e.kind = $urandom_range(0, 5) == 0 ? 2'd3 : KIND_END;
                    send_word(e);
                    n++;
                end
                if ($urandom_range(0, 2) == 0) idle_gap();
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/arb_pkg.sv
sv/arb_mac.sv
sv/arb_divsqrt.sv
sv/arcball_rotation_tracker_top.sv
tb/tb_top.sv
